@@ src/gtsp_pkg.sv @@
// shared types and constants for the grid threshold shortest path block
`default_nettype none

package gtsp_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;

    localparam int DIST_W    = 24;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DW    = 64;

    localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};
    localparam logic [DIST_W-1:0] DIST_SAT = {{(DIST_W-1){1'b1}}, 1'b0};

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_THRESHOLD = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_X         = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y         = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_END_X           = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_END_Y           = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_TABLE = 4'd7;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [7:0] pixel_value;
    } item_t;

    typedef struct packed {
        logic [5:0] point_x;
        logic [5:0] point_y;
        logic       found;
        logic       last;
    } result_t;

endpackage

`default_nettype wire

@@ src/gtsp_ram.sv @@
// generic single-port-write ram with registered read
`default_nettype none

module gtsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ src/grid_threshold_shortest_path.sv @@
// top level: image load, dijkstra search over ram state, path readout
//
//  channel  dir  handshake              payload
//  item     in   item_valid/item_stall  item_t (operation, pixel_value)
//  result   out  result_valid/stall     result_t (point_x, point_y, found, last)
//  cfg      in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// a load is taken while idle; a fetch with a cached path goes through the fetch and emit states
// the first fetch after a load or register write runs the search first:
// step-cost square roots for each direction, then clearing the distances,
// then per settled pixel a scan plus a relax step per direction,
// then the count and fill walks over the path points
// the dist ram single read port sets the pace: every scan and relax goes through it
// item_stall is high from an accepted fetch until its result sits in the output register

`default_nettype none

module grid_threshold_shortest_path
    import gtsp_pkg::*;
#(
    parameter int MAX_DIRECTIONS = 8,
    parameter int FRAC_BITS      = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_stall,
    input  wire item_t                item,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output result_t                   result,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DW-1:0]    cfg_data
);

    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int NW    = AW + 1;
    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int PW    = XW + YW;
    localparam int KW    = (MAX_DIRECTIONS > 1) ? $clog2(MAX_DIRECTIONS) : 1;
    localparam int XSW   = ((XW > 4) ? XW : 4) + 2;
    localparam int YSW   = ((YW > 4) ? YW : 4) + 2;
    localparam int SQ_W  = 8 + 2 * FRAC_BITS;
    localparam int VW    = SQ_W + 1;
    localparam int ITER  = SQ_W / 2;
    localparam int IW    = $clog2(ITER + 1);
    localparam int CW    = FRAC_BITS + 4;
    localparam int DW    = DIST_W + 1;

    typedef enum logic [19:0] {
        ST_IDLE      = 20'h00001,
        ST_START     = 20'h00002,
        ST_COST_LOAD = 20'h00004,
        ST_COST_STEP = 20'h00008,
        ST_COST_FIN  = 20'h00010,
        ST_CLEAR     = 20'h00020,
        ST_INIT      = 20'h00040,
        ST_SCAN_INIT = 20'h00080,
        ST_SCAN      = 20'h00100,
        ST_SCAN_LAST = 20'h00200,
        ST_SETTLE    = 20'h00400,
        ST_RELAX_A   = 20'h00800,
        ST_RELAX_B   = 20'h01000,
        ST_RELAX_C   = 20'h02000,
        ST_WALK_CHK  = 20'h04000,
        ST_WALK_ADDR = 20'h08000,
        ST_WALK_RD   = 20'h10000,
        ST_WALK_DAT  = 20'h20000,
        ST_FETCH     = 20'h40000,
        ST_EMIT      = 20'h80000
    } state_t;

    state_t state_reg;

    // configuration
    logic [6:0]  cfg_width_reg, cfg_height_reg;
    logic [8:0]  cfg_thr_reg;
    logic [5:0]  cfg_sx_reg, cfg_sy_reg, cfg_ex_reg, cfg_ey_reg;
    logic [63:0] cfg_dir_reg;

    // frame and search bookkeeping
    logic [NW-1:0] load_count_reg;
    logic          frame_closed_reg, search_valid_reg, found_reg;
    logic [NW-1:0] path_len_reg, fetch_pos_reg;

    // geometry of the running search
    logic [NW-1:0] n_reg;
    logic [AW-1:0] s_reg, e_reg;
    logic [XW-1:0] sx_reg, ex_reg;
    logic [YW-1:0] sy_reg, ey_reg;

    // step cost square root
    logic [KW-1:0] k_reg;
    logic [VW-1:0] sq_v_reg, sq_r_reg, sq_bit_reg;
    logic [IW-1:0] iter_reg;
    logic [CW-1:0] cost_reg [MAX_DIRECTIONS];

    // clear and scan
    logic [AW-1:0]     ci_reg, si_reg;
    logic [XW-1:0]     sc_x_reg;
    logic [YW-1:0]     sc_y_reg;
    logic              p_valid_reg;
    logic [AW-1:0]     p_idx_reg;
    logic [XW-1:0]     p_x_reg;
    logic [YW-1:0]     p_y_reg;
    logic              best_ok_reg;
    logic [AW-1:0]     best_reg;
    logic [XW-1:0]     bx_reg;
    logic [YW-1:0]     by_reg;
    logic [DIST_W-1:0] bd_reg;

    // relax
    logic [AW-1:0] ni_reg;

    // path walk
    logic [XW-1:0] cx_reg;
    logic [YW-1:0] cy_reg;
    logic [NW-1:0] wlen_reg;
    logic [AW-1:0] wpos_reg, walk_addr_reg;
    logic          fill_reg;

    // output register
    logic    result_valid_reg;
    result_t result_reg;

    // ram ports
    logic          pix_we;
    logic [AW-1:0] pix_waddr;
    logic [7:0]    pix_rdata;
    logic          dist_we;
    logic [AW-1:0] dist_waddr, dist_raddr;
    logic [DW-1:0] dist_wdata, dist_rdata;
    logic          pred_we;
    logic [AW-1:0] pred_waddr;
    logic [PW-1:0] pred_wdata, pred_rdata;
    logic          path_we;
    logic [PW-1:0] path_rdata;

    logic item_acc, result_acc, emit_fire;
    logic [NW-1:0] load_eff;

    assign item_acc   = item_valid && !item_stall;
    assign result_acc = result_valid_reg && !result_stall;
    assign item_stall = (state_reg != ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign result_valid = result_valid_reg;
    assign result     = result_reg;
    assign load_eff   = frame_closed_reg ? '0 : load_count_reg;
    // output register is free or drains this cycle
    assign emit_fire  = (state_reg == ST_EMIT) && (!result_valid_reg || !result_stall);

    // direction decode for the current k
    logic [7:0]        dir_byte;
    logic signed [3:0] dx_s, dy_s;
    logic [3:0]        adx, ady;
    logic [7:0]        d2;
    logic signed [XSW-1:0] nx_s;
    logic signed [YSW-1:0] ny_s;
    logic [XW-1:0]     nx_u;
    logic [YW-1:0]     ny_u;
    logic              step_ok;

    always_comb
    begin
        dir_byte = cfg_dir_reg[{k_reg, 3'b000} +: 8];
        dx_s = signed'(dir_byte[7:4]);
        dy_s = signed'(dir_byte[3:0]);
        adx  = dir_byte[7] ? 4'(-dir_byte[7:4]) : dir_byte[7:4];
        ady  = dir_byte[3] ? 4'(-dir_byte[3:0]) : dir_byte[3:0];
        d2   = 8'({4'b0, adx} * {4'b0, adx}) + 8'({4'b0, ady} * {4'b0, ady});
        nx_s = $signed({{(XSW-XW){1'b0}}, bx_reg}) + XSW'(dx_s);
        ny_s = $signed({{(YSW-YW){1'b0}}, by_reg}) + YSW'(dy_s);
        nx_u = XW'(nx_s);
        ny_u = YW'(ny_s);
        step_ok = (dir_byte != 8'd0)
                  && !nx_s[XSW-1] && (int'(nx_s) < int'(cfg_width_reg))
                  && !ny_s[YSW-1] && (int'(ny_s) < int'(cfg_height_reg));
    end

    // candidate distance for relaxation
    logic [DIST_W:0]   nd_sum;
    logic [DIST_W-1:0] nd;
    logic              relax_upd;

    always_comb
    begin
        nd_sum = {1'b0, bd_reg} + (DIST_W+1)'(cost_reg[k_reg]);
        nd = (nd_sum > {1'b0, DIST_SAT}) ? DIST_SAT : nd_sum[DIST_W-1:0];
        relax_upd = ({1'b0, pix_rdata} >= cfg_thr_reg) && (nd < dist_rdata[DIST_W-1:0]);
    end

    // scan compare on data returned by the dist ram
    logic          scan_take;
    logic [VW-1:0] sq_t;
    logic          geom_bad;

    assign scan_take = p_valid_reg && !dist_rdata[DIST_W]
                       && (dist_rdata[DIST_W-1:0] < bd_reg);
    assign sq_t = sq_r_reg + sq_bit_reg;
    assign geom_bad = (cfg_width_reg == 7'd0) || (int'(cfg_width_reg) > MAX_WIDTH)
                      || (cfg_height_reg == 7'd0) || (int'(cfg_height_reg) > MAX_HEIGHT)
                      || ({1'b0, cfg_sx_reg} >= cfg_width_reg)
                      || ({1'b0, cfg_sy_reg} >= cfg_height_reg)
                      || ({1'b0, cfg_ex_reg} >= cfg_width_reg)
                      || ({1'b0, cfg_ey_reg} >= cfg_height_reg);

    // ram port muxing
    always_comb
    begin
        pix_we    = item_acc && (item.operation == OP_LOAD) && (int'(load_eff) < CELLS);
        pix_waddr = AW'(load_eff);

        dist_we    = 1'b0;
        dist_waddr = ci_reg;
        dist_wdata = {1'b0, DIST_INF};
        pred_we    = 1'b0;
        pred_waddr = s_reg;
        pred_wdata = {sx_reg, sy_reg};
        path_we    = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                dist_we = 1'b1;
            end
            ST_INIT:
            begin
                dist_we    = 1'b1;
                dist_waddr = s_reg;
                dist_wdata = '0;
                pred_we    = 1'b1;
            end
            ST_SETTLE:
            begin
                dist_we    = best_ok_reg;
                dist_waddr = best_reg;
                dist_wdata = {1'b1, bd_reg};
            end
            ST_RELAX_C:
            begin
                dist_we    = relax_upd;
                dist_waddr = ni_reg;
                dist_wdata = {dist_rdata[DIST_W], nd};
                pred_we    = relax_upd;
                pred_waddr = ni_reg;
                pred_wdata = {bx_reg, by_reg};
            end
            ST_WALK_CHK:
            begin
                path_we = fill_reg;
            end
            default:
            begin
            end
        endcase
        dist_raddr = (state_reg == ST_RELAX_B) ? ni_reg : si_reg;
    end

    gtsp_ram #(.WIDTH(8), .DEPTH(CELLS)) u_pix_ram (
        .clk   (clk),
        .we    (pix_we),
        .waddr (pix_waddr),
        .wdata (item.pixel_value),
        .raddr (ni_reg),
        .rdata (pix_rdata)
    );

    gtsp_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_dist_ram (
        .clk   (clk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (dist_wdata),
        .raddr (dist_raddr),
        .rdata (dist_rdata)
    );

    gtsp_ram #(.WIDTH(PW), .DEPTH(CELLS)) u_pred_ram (
        .clk   (clk),
        .we    (pred_we),
        .waddr (pred_waddr),
        .wdata (pred_wdata),
        .raddr (walk_addr_reg),
        .rdata (pred_rdata)
    );

    gtsp_ram #(.WIDTH(PW), .DEPTH(CELLS)) u_path_ram (
        .clk   (clk),
        .we    (path_we),
        .waddr (wpos_reg),
        .wdata ({cx_reg, cy_reg}),
        .raddr (AW'(fetch_pos_reg)),
        .rdata (path_rdata)
    );

    // step costs, no reset needed
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_COST_FIN)
        begin
            cost_reg[k_reg] <= CW'(sq_r_reg + VW'(sq_v_reg > sq_r_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cfg_width_reg    <= 7'd64;
            cfg_height_reg   <= 7'd64;
            cfg_thr_reg      <= '0;
            cfg_sx_reg       <= '0;
            cfg_sy_reg       <= '0;
            cfg_ex_reg       <= '0;
            cfg_ey_reg       <= '0;
            cfg_dir_reg      <= 64'h0F01F010;
            load_count_reg   <= '0;
            frame_closed_reg <= 1'b0;
            search_valid_reg <= 1'b0;
            found_reg        <= 1'b0;
            path_len_reg     <= '0;
            fetch_pos_reg    <= '0;
            n_reg            <= '0;
            s_reg            <= '0;
            e_reg            <= '0;
            sx_reg           <= '0;
            sy_reg           <= '0;
            ex_reg           <= '0;
            ey_reg           <= '0;
            k_reg            <= '0;
            sq_v_reg         <= '0;
            sq_r_reg         <= '0;
            sq_bit_reg       <= '0;
            iter_reg         <= '0;
            ci_reg           <= '0;
            si_reg           <= '0;
            sc_x_reg         <= '0;
            sc_y_reg         <= '0;
            p_valid_reg      <= 1'b0;
            p_idx_reg        <= '0;
            p_x_reg          <= '0;
            p_y_reg          <= '0;
            best_ok_reg      <= 1'b0;
            best_reg         <= '0;
            bx_reg           <= '0;
            by_reg           <= '0;
            bd_reg           <= DIST_INF;
            ni_reg           <= '0;
            cx_reg           <= '0;
            cy_reg           <= '0;
            wlen_reg         <= '0;
            wpos_reg         <= '0;
            walk_addr_reg    <= '0;
            fill_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            if (result_acc && !emit_fire)
            begin
                result_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (item_acc)
                    begin
                        if (item.operation == OP_LOAD)
                        begin
                            frame_closed_reg <= 1'b0;
                            search_valid_reg <= 1'b0;
                            if (int'(load_eff) < CELLS)
                            begin
                                load_count_reg <= load_eff + 1'b1;
                            end
                            else
                            begin
                                load_count_reg <= load_eff;
                            end
                        end
                        else
                        begin
                            frame_closed_reg <= 1'b1;
                            state_reg <= search_valid_reg ? ST_FETCH : ST_START;
                        end
                    end
                end

                ST_START:
                begin
                    found_reg     <= 1'b0;
                    path_len_reg  <= '0;
                    fetch_pos_reg <= '0;
                    n_reg  <= NW'(NW'(cfg_width_reg) * NW'(cfg_height_reg));
                    s_reg  <= AW'(AW'(cfg_sy_reg) * AW'(cfg_width_reg) + AW'(cfg_sx_reg));
                    e_reg  <= AW'(AW'(cfg_ey_reg) * AW'(cfg_width_reg) + AW'(cfg_ex_reg));
                    sx_reg <= XW'(cfg_sx_reg);
                    sy_reg <= YW'(cfg_sy_reg);
                    ex_reg <= XW'(cfg_ex_reg);
                    ey_reg <= YW'(cfg_ey_reg);
                    k_reg  <= '0;
                    if (geom_bad)
                    begin
                        search_valid_reg <= 1'b1;
                        state_reg <= ST_FETCH;
                    end
                    else
                    begin
                        state_reg <= ST_COST_LOAD;
                    end
                end

                ST_COST_LOAD:
                begin
                    sq_v_reg   <= VW'(d2) << (2 * FRAC_BITS);
                    sq_r_reg   <= '0;
                    sq_bit_reg <= VW'(1) << (SQ_W - 2);
                    iter_reg   <= '0;
                    state_reg  <= ST_COST_STEP;
                end

                // one result bit of the square root per cycle
                ST_COST_STEP:
                begin
                    if (sq_v_reg >= sq_t)
                    begin
                        sq_v_reg <= sq_v_reg - sq_t;
                        sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                    end
                    else
                    begin
                        sq_r_reg <= sq_r_reg >> 1;
                    end
                    sq_bit_reg <= sq_bit_reg >> 2;
                    iter_reg   <= iter_reg + 1'b1;
                    if (int'(iter_reg) == ITER - 1)
                    begin
                        state_reg <= ST_COST_FIN;
                    end
                end

                ST_COST_FIN:
                begin
                    if (int'(k_reg) == MAX_DIRECTIONS - 1)
                    begin
                        ci_reg    <= '0;
                        state_reg <= ST_CLEAR;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_COST_LOAD;
                    end
                end

                ST_CLEAR:
                begin
                    ci_reg <= ci_reg + 1'b1;
                    if (int'(ci_reg) + 1 == int'(n_reg))
                    begin
                        state_reg <= ST_INIT;
                    end
                end

                ST_INIT:
                begin
                    state_reg <= ST_SCAN_INIT;
                end

                ST_SCAN_INIT:
                begin
                    si_reg      <= '0;
                    sc_x_reg    <= '0;
                    sc_y_reg    <= '0;
                    p_valid_reg <= 1'b0;
                    best_ok_reg <= 1'b0;
                    bd_reg      <= DIST_INF;
                    state_reg   <= ST_SCAN;
                end

                ST_SCAN, ST_SCAN_LAST:
                begin
                    // strict compare keeps the lowest index on equal distance
                    if (scan_take)
                    begin
                        best_ok_reg <= 1'b1;
                        bd_reg      <= dist_rdata[DIST_W-1:0];
                        best_reg    <= p_idx_reg;
                        bx_reg      <= p_x_reg;
                        by_reg      <= p_y_reg;
                    end
                    if (state_reg == ST_SCAN)
                    begin
                        p_valid_reg <= 1'b1;
                        p_idx_reg   <= si_reg;
                        p_x_reg     <= sc_x_reg;
                        p_y_reg     <= sc_y_reg;
                        si_reg      <= si_reg + 1'b1;
                        if (int'(sc_x_reg) + 1 == int'(cfg_width_reg))
                        begin
                            sc_x_reg <= '0;
                            sc_y_reg <= sc_y_reg + 1'b1;
                        end
                        else
                        begin
                            sc_x_reg <= sc_x_reg + 1'b1;
                        end
                        if (int'(si_reg) + 1 == int'(n_reg))
                        begin
                            state_reg <= ST_SCAN_LAST;
                        end
                    end
                    else
                    begin
                        p_valid_reg <= 1'b0;
                        state_reg   <= ST_SETTLE;
                    end
                end

                ST_SETTLE:
                begin
                    k_reg <= '0;
                    if (!best_ok_reg)
                    begin
                        search_valid_reg <= 1'b1;
                        state_reg <= ST_FETCH;
                    end
                    else if (best_reg == e_reg)
                    begin
                        cx_reg    <= ex_reg;
                        cy_reg    <= ey_reg;
                        wlen_reg  <= NW'(1);
                        fill_reg  <= 1'b0;
                        state_reg <= ST_WALK_CHK;
                    end
                    else
                    begin
                        state_reg <= ST_RELAX_A;
                    end
                end

                ST_RELAX_A:
                begin
                    ni_reg <= AW'(AW'(ny_u) * AW'(cfg_width_reg) + AW'(nx_u));
                    if (step_ok)
                    begin
                        state_reg <= ST_RELAX_B;
                    end
                    else if (int'(k_reg) == MAX_DIRECTIONS - 1)
                    begin
                        state_reg <= ST_SCAN_INIT;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end

                ST_RELAX_B:
                begin
                    state_reg <= ST_RELAX_C;
                end

                ST_RELAX_C:
                begin
                    if (int'(k_reg) == MAX_DIRECTIONS - 1)
                    begin
                        state_reg <= ST_SCAN_INIT;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_RELAX_A;
                    end
                end

                // first pass counts the path, second writes it back to front
                ST_WALK_CHK:
                begin
                    if (!fill_reg)
                    begin
                        if (((cx_reg == sx_reg) && (cy_reg == sy_reg)) || (wlen_reg >= n_reg))
                        begin
                            fill_reg  <= 1'b1;
                            cx_reg    <= ex_reg;
                            cy_reg    <= ey_reg;
                            wpos_reg  <= AW'(wlen_reg - 1'b1);
                        end
                        else
                        begin
                            state_reg <= ST_WALK_ADDR;
                        end
                    end
                    else if (wpos_reg == '0)
                    begin
                        found_reg        <= 1'b1;
                        search_valid_reg <= 1'b1;
                        path_len_reg     <= wlen_reg;
                        fetch_pos_reg    <= '0;
                        state_reg        <= ST_FETCH;
                    end
                    else
                    begin
                        wpos_reg  <= wpos_reg - 1'b1;
                        state_reg <= ST_WALK_ADDR;
                    end
                end

                ST_WALK_ADDR:
                begin
                    walk_addr_reg <= AW'(AW'(cy_reg) * AW'(cfg_width_reg) + AW'(cx_reg));
                    state_reg     <= ST_WALK_RD;
                end

                ST_WALK_RD:
                begin
                    state_reg <= ST_WALK_DAT;
                end

                ST_WALK_DAT:
                begin
                    cx_reg <= pred_rdata[PW-1:YW];
                    cy_reg <= pred_rdata[YW-1:0];
                    if (!fill_reg)
                    begin
                        wlen_reg <= wlen_reg + 1'b1;
                    end
                    state_reg <= ST_WALK_CHK;
                end

                ST_FETCH:
                begin
                    state_reg <= ST_EMIT;
                end

                ST_EMIT:
                begin
                    // wait for the output register to drain
                    if (emit_fire)
                    begin
                        result_valid_reg <= 1'b1;
                        if (!found_reg)
                        begin
                            result_reg <= '{point_x: 6'd0, point_y: 6'd0, found: 1'b0,
                                            last: 1'b1};
                        end
                        else
                        begin
                            result_reg <= '{point_x: 6'(path_rdata[PW-1:YW]),
                                            point_y: 6'(path_rdata[YW-1:0]),
                                            found: 1'b1,
                                            last: (fetch_pos_reg + 1'b1 == path_len_reg)};
                            if (fetch_pos_reg + 1'b1 >= path_len_reg)
                            begin
                                fetch_pos_reg <= '0;
                            end
                            else
                            begin
                                fetch_pos_reg <= fetch_pos_reg + 1'b1;
                            end
                        end
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // register writes are to arrive only while idle; the block itself does not enforce this
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:     cfg_width_reg  <= cfg_data[6:0];
                    REG_IMAGE_HEIGHT:    cfg_height_reg <= cfg_data[6:0];
                    REG_PIXEL_THRESHOLD: cfg_thr_reg    <= cfg_data[8:0];
                    REG_START_X:         cfg_sx_reg     <= cfg_data[5:0];
                    REG_START_Y:         cfg_sy_reg     <= cfg_data[5:0];
                    REG_END_X:           cfg_ex_reg     <= cfg_data[5:0];
                    REG_END_Y:           cfg_ey_reg     <= cfg_data[5:0];
                    REG_DIRECTION_TABLE: cfg_dir_reg    <= cfg_data;
                    default:
                    begin
                    end
                endcase
                if (cfg_index <= REG_DIRECTION_TABLE)
                begin
                    search_valid_reg <= 1'b0;
                    fetch_pos_reg    <= '0;
                end
            end
        end
    end

    a_fetch_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (item_acc && (item.operation == OP_FETCH)) |=> (state_reg != ST_IDLE))
        else $error("accepted fetch did not start work");

    a_fetch_pos_in_path: assert property (@(posedge clk) disable iff (!rst_n)
        (search_valid_reg && found_reg) |-> (fetch_pos_reg < path_len_reg))
        else $error("fetch position past path length");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) || (state_reg == ST_SCAN_LAST)) |-> !dist_we)
        else $error("distance write during scan");

    a_emit_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EMIT) && !(result_valid_reg && result_stall)) |=> result_valid_reg)
        else $error("emit without result");

endmodule

`default_nettype wire

@@ tb/sv/tb_grid_threshold_shortest_path.sv @@
// self-checking testbench for the grid threshold shortest path block
`default_nettype none

module tb_grid_threshold_shortest_path;
    import gtsp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELL_COUNT  = 4096;
    localparam int IDLE_LIMIT  = 100000;
    localparam int HOLD_CYCLES = 400;
    localparam logic [63:0] DIRS_FOUR  = 64'h0F01F010;
    localparam logic [63:0] DIRS_EIGHT = 64'h111FF1FF10F0010F;

    // path predictor and store of expected path points
    class path_scoreboard;
        int unsigned img_w, img_h, thresh, sx, sy, ex, ey;
        logic [63:0] dir_table;
        byte unsigned pixels[CELL_COUNT];
        int unsigned dist_tab[CELL_COUNT];
        int unsigned pred[CELL_COUNT];
        bit settled[CELL_COUNT];
        int unsigned path_pts[CELL_COUNT];
        int unsigned load_count, path_len, fetch_pos;
        bit frame_closed, search_valid, found_flag;
        result_t expected_points[$];
        int mismatches;

        function new();
            img_w = 64;
            img_h = 64;
            thresh = 0;
            sx = 0;
            sy = 0;
            ex = 0;
            ey = 0;
            dir_table = DIRS_FOUR;
            foreach (dist_tab[i]) dist_tab[i] = 32'hFFFFFF;
            load_count = 0;
            path_len = 0;
            fetch_pos = 0;
            frame_closed = 0;
            search_valid = 0;
            found_flag = 0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DW-1:0] d);
            case (idx)
                REG_IMAGE_WIDTH:     img_w = d[6:0];
                REG_IMAGE_HEIGHT:    img_h = d[6:0];
                REG_PIXEL_THRESHOLD: thresh = d[8:0];
                REG_START_X:         sx = d[5:0];
                REG_START_Y:         sy = d[5:0];
                REG_END_X:           ex = d[5:0];
                REG_END_Y:           ey = d[5:0];
                REG_DIRECTION_TABLE: dir_table = d;
                default:             return;
            endcase
            search_valid = 0;
            fetch_pos = 0;
        endfunction

        function void search();
            int unsigned n, s, e, best, bd, cur, ni, nd, v, r;
            int dxs[8], dys[8];
            int unsigned cost[8];
            bit used[8];
            logic [7:0] b;
            int cx, cy, nx, ny;
            search_valid = 1;
            found_flag = 0;
            path_len = 0;
            fetch_pos = 0;
            if (img_w < 1 || img_w > 64 || img_h < 1 || img_h > 64) return;
            if (sx >= img_w || sy >= img_h || ex >= img_w || ey >= img_h) return;
            n = img_w * img_h;
            s = sy * img_w + sx;
            e = ey * img_w + ex;
            for (int k = 0; k < 8; k++) begin
                b = dir_table[8*k +: 8];
                used[k] = (b != 0);
                dxs[k] = $signed(b[7:4]);
                dys[k] = $signed(b[3:0]);
                // rounded square root of the squared length, 8 fraction bits
                v = (dxs[k] * dxs[k] + dys[k] * dys[k]) << 16;
                r = 0;
                while ((r + 1) * (r + 1) <= v) r++;
                if (v - r * r > r) r++;
                cost[k] = r;
            end
            for (int i = 0; i < n; i++)
            begin
                dist_tab[i] = 32'hFFFFFF;
                settled[i] = 0;
            end
            dist_tab[s] = 0;
            pred[s] = s;
            forever
            begin
                best = n;
                bd = 32'hFFFFFF;
                for (int i = 0; i < n; i++)
                    if (!settled[i] && dist_tab[i] < bd)
                    begin
                        bd = dist_tab[i];
                        best = i;
                    end
                if (best == n) return;
                settled[best] = 1;
                if (best == e) break;
                cx = best % img_w;
                cy = best / img_w;
                for (int k = 0; k < 8; k++)
                begin
                    nx = cx + dxs[k];
                    ny = cy + dys[k];
                    if (!used[k]) continue;
                    if (nx < 0 || ny < 0 || nx >= int'(img_w) || ny >= int'(img_h)) continue;
                    ni = ny * img_w + nx;
                    if (pixels[ni] < thresh) continue;
                    nd = bd + cost[k];
                    if (nd > 32'hFFFFFE) nd = 32'hFFFFFE;
                    if (nd < dist_tab[ni])
                    begin
                        dist_tab[ni] = nd;
                        pred[ni] = best;
                    end
                end
            end
            cur = e;
            path_len = 1;
            while (cur != s && path_len < n)
            begin
                cur = pred[cur % CELL_COUNT];
                path_len++;
            end
            cur = e;
            for (int i = path_len; i > 0; i--)
            begin
                path_pts[i-1] = cur;
                cur = pred[cur % CELL_COUNT];
            end
            found_flag = 1;
        endfunction

        function void note_item(item_t it);
            result_t pt;
            int unsigned idx;
            if (it.operation == OP_LOAD)
            begin
                if (frame_closed)
                begin
                    load_count = 0;
                    frame_closed = 0;
                end
                if (load_count < CELL_COUNT)
                begin
                    pixels[load_count] = it.pixel_value;
                    load_count++;
                end
                search_valid = 0;
                return;
            end
            frame_closed = 1;
            if (!search_valid) search();
            pt = '0;
            if (!found_flag || path_len == 0)
                pt.last = 1;
            else
            begin
                if (fetch_pos >= path_len) fetch_pos = 0;
                idx = path_pts[fetch_pos];
                pt.point_x = 6'(idx % img_w);
                pt.point_y = 6'(idx / img_w);
                pt.found = 1;
                pt.last = (fetch_pos + 1 == path_len);
                fetch_pos++;
                if (fetch_pos >= path_len) fetch_pos = 0;
            end
            expected_points.insert(expected_points.size(), pt);
        endfunction

        function void check_result(result_t r);
            result_t e;
            if (expected_points.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result x=%0d y=%0d found=%0d last=%0d",
                             r.point_x, r.point_y, r.found, r.last);
                return;
            end
            e = expected_points.pop_front();
            if (r.point_x !== e.point_x || r.point_y !== e.point_y ||
                r.found !== e.found || r.last !== e.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("expected %0d,%0d f=%0d l=%0d got %0d,%0d f=%0d l=%0d",
                             e.point_x, e.point_y, e.found, e.last,
                             r.point_x, r.point_y, r.found, r.last);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic item_valid = 0;
    logic item_stall;
    item_t item = '0;
    logic result_valid;
    logic result_stall = 0;
    result_t result;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DW-1:0] cfg_data = '0;

    path_scoreboard sb = new();
    int burst_left = 0;
    int items_sent = 0;
    bit hold_req = 0;
    int idle_cycles = 0;

    grid_threshold_shortest_path DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    // receiver: checks each result transfer, stalls on a shifting pattern
    initial
    begin
        int hold_left;
        int cyc;
        hold_left = 0;
        cyc = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (result_valid && !result_stall) sb.check_result(result);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1;
            end
            else
                case ((cyc / 97) % 3)
                    0: result_stall <= 0;
                    1: result_stall <= ($urandom_range(0, 3) == 0);
                    default: result_stall <= ($urandom_range(0, 3) != 0);
                endcase
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("grid_threshold_shortest_path: mismatch");
            $finish;
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DW-1:0] d);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, d);
    endtask

    task automatic send_item(logic op, logic [7:0] pix);
        item_t it;
        it.operation = op;
        it.pixel_value = pix;
        if (burst_left == 0)
        begin
            item_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
        item_valid <= 1;
        item <= it;
        do @(posedge clk); while (item_stall);
        sb.note_item(it);
        items_sent++;
        burst_left--;
    endtask

    // junk above the register width must be ignored
    function automatic logic [CFG_DW-1:0] pad(int unsigned v, int bits);
        logic [CFG_DW-1:0] d;
        d = {$urandom, $urandom};
        if ($urandom_range(0, 1)) d = '0;
        d = (d << bits) | CFG_DW'(v);
        return d;
    endfunction

    task automatic run_phase(int unsigned w, int unsigned h, int unsigned thr,
                             int unsigned stx, int unsigned sty,
                             int unsigned enx, int unsigned eny,
                             logic [63:0] dirs, bit hold);
        bit geom_ok;
        int nload;
        logic [7:0] pix;
        geom_ok = (w >= 1 && w <= 64 && h >= 1 && h <= 64);
        cfg_write(REG_IMAGE_WIDTH, pad(w, 7));
        cfg_write(REG_IMAGE_HEIGHT, pad(h, 7));
        cfg_write(REG_PIXEL_THRESHOLD, pad(thr, 9));
        cfg_write(REG_START_X, pad(stx, 6));
        cfg_write(REG_START_Y, pad(sty, 6));
        cfg_write(REG_END_X, pad(enx, 6));
        cfg_write(REG_END_Y, pad(eny, 6));
        cfg_write(REG_DIRECTION_TABLE, dirs);
        cfg_valid <= 0;
        repeat ($urandom_range(1, 2))
        begin
            nload = geom_ok ? w * h : $urandom_range(0, 3);
            for (int i = 0; i < nload; i++)
            begin
                // most pixels pass the threshold so that paths exist
                if (thr == 0 || thr > 255 || $urandom_range(0, 9) < 7)
                    pix = (thr > 255) ? $urandom_range(0, 255) : $urandom_range(thr, 255);
                else
                    pix = $urandom_range(0, thr - 1);
                send_item(OP_LOAD, pix);
            end
            if (hold) hold_req = 1;
            repeat ($urandom_range(1, 24)) send_item(OP_FETCH, $urandom_range(0, 255));
        end
        item_valid <= 0;
        burst_left = 0;
        while (sb.expected_points.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    function automatic logic [63:0] pick_dirs();
        logic [63:0] d;
        case ($urandom_range(0, 4))
            0: d = DIRS_FOUR;
            1: d = DIRS_EIGHT;
            2: d = {$urandom, $urandom};
            default:
            begin
                d = {$urandom, $urandom};
                for (int k = 0; k < 8; k++)
                    if ($urandom_range(0, 3) == 0) d[8*k +: 8] = 8'h00;
            end
        endcase
        return d;
    endfunction

    initial
    begin
        int unsigned w, h, thr, stx, sty, enx, eny;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        repeat (2) @(posedge clk);

        // directed: corners, thresholds, empty and full direction tables, bad geometry
        run_phase(4, 4, 0, 0, 0, 3, 3, DIRS_FOUR, 0);
        run_phase(4, 3, 128, 3, 2, 0, 0, DIRS_EIGHT, 1);
        run_phase(3, 3, 255, 1, 1, 1, 1, DIRS_FOUR, 0);
        run_phase(3, 2, 256, 0, 0, 2, 1, DIRS_EIGHT, 0);
        run_phase(2, 2, 511, 0, 0, 1, 1, DIRS_FOUR, 0);
        run_phase(3, 3, 0, 0, 0, 2, 2, 64'h0, 0);
        run_phase(3, 3, 0, 2, 2, 0, 0, 64'hFFFFFFFFFFFFFFFF, 0);
        run_phase(64, 1, 0, 0, 0, 63, 0, DIRS_FOUR, 0);
        run_phase(1, 64, 0, 0, 63, 0, 0, DIRS_FOUR, 0);
        run_phase(0, 4, 0, 0, 0, 0, 0, DIRS_FOUR, 0);
        run_phase(127, 127, 0, 0, 0, 1, 1, DIRS_FOUR, 0);
        run_phase(4, 4, 0, 5, 0, 3, 3, DIRS_FOUR, 0);
        run_phase(5, 3, 0, 0, 0, 4, 2, 64'h0000000000211F12, 0);

        while (items_sent < 1700)
        begin
            case ($urandom_range(0, 19))
                0, 1:
                begin
                    w = $urandom_range(1, 64);
                    h = 64 / w;
                    if ($urandom_range(0, 1)) {w, h} = {h, w};
                end
                2:
                begin
                    w = $urandom_range(0, 1) ? 0 : $urandom_range(65, 127);
                    h = $urandom_range(0, 127);
                end
                default:
                begin
                    w = $urandom_range(1, 8);
                    h = $urandom_range(1, 8);
                end
            endcase
            case ($urandom_range(0, 9))
                0: thr = 0;
                1: thr = $urandom_range(256, 511);
                default: thr = $urandom_range(0, 255);
            endcase
            if ($urandom_range(0, 6) != 0 && w >= 1 && w <= 64 && h >= 1 && h <= 64)
            begin
                stx = $urandom_range(0, w - 1);
                sty = $urandom_range(0, h - 1);
                enx = $urandom_range(0, w - 1);
                eny = $urandom_range(0, h - 1);
            end
            else
            begin
                stx = $urandom_range(0, 63);
                sty = $urandom_range(0, 63);
                enx = $urandom_range(0, 63);
                eny = $urandom_range(0, 63);
            end
            run_phase(w, h, thr, stx, sty, enx, eny, pick_dirs(),
                      $urandom_range(0, 29) == 0);
        end

        repeat (32) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_points.size() == 0)
            $display("grid_threshold_shortest_path: match");
        else
            $display("grid_threshold_shortest_path: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

@@ grid_threshold_shortest_path.f @@
src/gtsp_pkg.sv
src/gtsp_ram.sv
src/grid_threshold_shortest_path.sv
tb/sv/tb_grid_threshold_shortest_path.sv
